/* sv/krtsd_pkg.sv */
package krtsd_pkg;

    // operation codes
    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_UPDATE = 3'd1,
        OP_LOOKUP = 3'd2,
        OP_DUMP   = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    localparam int KEY_W = 64;
    localparam int REF_W = 31;
    localparam int CNT_W = 7;

    // controller -> datapath
    typedef struct packed {
        logic load;        // latch a new transaction
        logic scan_start;  // rewind scan counter, clear scan results
        logic dump_init;   // first pass of a dump
        logic scan_step;   // issue one table read
        logic emit;        // produce one result and commit
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] op;
        logic       fill_zero;
        logic       scan_last;
        logic       dump_last;
    } t_status;

endpackage

/* sv/krtsd_ctrl.sv */
module krtsd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  krtsd_pkg::t_status i_status,
    output krtsd_pkg::t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   w_scan_op;

    assign busy = (r_state != S_IDLE);
    assign w_scan_op = (i_status.op == krtsd_pkg::OP_UPDATE) ||
                       (i_status.op == krtsd_pkg::OP_LOOKUP) ||
                       (i_status.op == krtsd_pkg::OP_DUMP);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (w_scan_op && !i_status.fill_zero) begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.dump_init  = 1'b1;
                    n_state          = S_SCAN;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if ((i_status.op == krtsd_pkg::OP_DUMP) && !i_status.fill_zero &&
                    !i_status.dump_last) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

/* sv/krtsd_dp.sv */
module krtsd_dp #(
    parameter int DEPTH     = 64,
    parameter int KEY_BYTES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  krtsd_pkg::t_cmd               i_cmd,
    output krtsd_pkg::t_status            o_status,
    input  logic [2:0]                    i_operation,
    input  logic [krtsd_pkg::KEY_W-1:0]   i_key,
    input  logic [krtsd_pkg::REF_W-1:0]   i_ref_value,
    output logic                          o_strobe,
    output logic                          o_found,
    output logic [krtsd_pkg::REF_W-1:0]   o_old_ref,
    output logic                          o_table_full,
    output logic                          o_entry_valid,
    output logic [krtsd_pkg::KEY_W-1:0]   o_entry_key,
    output logic [krtsd_pkg::REF_W-1:0]   o_entry_ref,
    output logic [krtsd_pkg::CNT_W-1:0]   o_entry_count,
    output logic                          o_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW = krtsd_pkg::KEY_W;
    localparam int RW = krtsd_pkg::REF_W;
    localparam int CW = krtsd_pkg::CNT_W;
    localparam logic [KW-1:0] KEY_MASK = {KW{1'b1}} << (8 * (8 - KEY_BYTES));

    // table storage
    logic [KW-1:0] key_mem [DEPTH];
    logic [RW-1:0] ref_mem [DEPTH];

    // transaction registers
    logic [2:0]    r_op;
    logic [KW-1:0] r_key;
    logic [RW-1:0] r_ref;
    logic [CW-1:0] r_fill, n_fill;

    // scan pipeline
    logic [CW-1:0] r_cnt;
    logic          r_pvld;
    logic [AW-1:0] r_pidx;
    logic [KW-1:0] r_rd_key;
    logic [RW-1:0] r_rd_ref;

    // update/lookup results
    logic          r_hit;
    logic [RW-1:0] r_old;

    // dump selection
    logic          r_best_vld;
    logic [KW-1:0] r_best_key;
    logic [AW-1:0] r_best_idx;
    logic [RW-1:0] r_best_ref;
    logic          r_have_prev;
    logic [KW-1:0] r_prev_key;
    logic [AW-1:0] r_prev_idx;
    logic [CW-1:0] r_dumped;

    logic          w_full, w_match, w_after_prev, w_before_best;
    logic          w_is_ins, w_is_upd, w_is_lkp, w_is_dump, w_is_clr;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [CW-1:0] w_cnt_inc, w_dump_inc;

    assign w_is_ins  = (r_op == krtsd_pkg::OP_INSERT);
    assign w_is_upd  = (r_op == krtsd_pkg::OP_UPDATE);
    assign w_is_lkp  = (r_op == krtsd_pkg::OP_LOOKUP);
    assign w_is_dump = (r_op == krtsd_pkg::OP_DUMP);
    assign w_is_clr  = (r_op == krtsd_pkg::OP_CLEAR);

    assign w_full     = (r_fill >= CW'(DEPTH));
    assign w_cnt_inc  = r_cnt + CW'(1);
    assign w_dump_inc = r_dumped + CW'(1);

    assign o_status.op        = r_op;
    assign o_status.fill_zero = (r_fill == '0);
    assign o_status.scan_last = (w_cnt_inc == r_fill);
    assign o_status.dump_last = (w_dump_inc == r_fill);

    // entry compare: order is key ascending, then newest first
    assign w_match       = (r_rd_key == r_key);
    assign w_after_prev  = !r_have_prev ||
                           ({r_rd_key, ~r_pidx} > {r_prev_key, ~r_prev_idx});
    assign w_before_best = !r_best_vld ||
                           ({r_rd_key, ~r_pidx} < {r_best_key, ~r_best_idx});

    // single write port: insert writes both stores, update writes references
    assign w_we    = (i_cmd.emit && w_is_ins && !w_full) || (r_pvld && w_is_upd && w_match);
    assign w_waddr = (r_pvld && w_is_upd) ? r_pidx : r_fill[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit && w_is_ins && !w_full) key_mem[w_waddr] <= r_key;
        if (w_we) ref_mem[w_waddr] <= (w_is_ins ? r_ref : r_ref);
        r_rd_key <= key_mem[r_cnt[AW-1:0]];
        r_rd_ref <= ref_mem[r_cnt[AW-1:0]];
    end

    // next fill count
    always_comb begin
        n_fill = r_fill;
        if (i_cmd.emit) begin
            if (w_is_ins && !w_full) n_fill = r_fill + CW'(1);
            else if (w_is_clr)       n_fill = '0;
        end
    end

    // transaction latch, scan and selection
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_key <= i_key & KEY_MASK;
            r_ref <= i_ref_value;
        end
        if (i_cmd.scan_start) begin
            r_cnt      <= '0;
            r_hit      <= 1'b0;
            r_old      <= '0;
            r_best_vld <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_cnt <= w_cnt_inc;
        end
        if (r_pvld) begin
            if (w_match && !r_hit) r_old <= r_rd_ref;
            if (w_match) r_hit <= 1'b1;
            if (w_after_prev && w_before_best) begin
                r_best_vld <= 1'b1;
                r_best_key <= r_rd_key;
                r_best_idx <= r_pidx;
                r_best_ref <= r_rd_ref;
            end
        end
        r_pidx <= r_cnt[AW-1:0];
        if (i_cmd.dump_init) begin
            r_have_prev <= 1'b0;
            r_dumped    <= '0;
        end else if (i_cmd.emit) begin
            r_have_prev <= 1'b1;
            r_prev_key  <= r_best_key;
            r_prev_idx  <= r_best_idx;
            r_dumped    <= w_dump_inc;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_pvld   <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_fill   <= n_fill;
            r_pvld   <= i_cmd.scan_step;
            o_strobe <= i_cmd.emit;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_found       <= (w_is_upd || w_is_lkp) && r_hit && (r_fill != '0);
            o_old_ref     <= (w_is_upd && r_hit && (r_fill != '0)) ? r_old : '0;
            o_table_full  <= w_is_ins && w_full;
            o_entry_valid <= w_is_dump && (r_fill != '0);
            o_entry_key   <= (w_is_dump && (r_fill != '0)) ? r_best_key : '0;
            o_entry_ref   <= (w_is_dump && (r_fill != '0)) ? r_best_ref : '0;
            o_entry_count <= n_fill;
            o_last        <= !(w_is_dump && (r_fill != '0)) || (w_dump_inc == r_fill);
        end
    end

endmodule

/* sv/key_ref_table_sorted_dump.sv */
// Channel   | Handshake          | Payload
// ----------+--------------------+-------------------------------------------
// command   | start / busy       | i_operation, i_key, i_ref_value
// result    | o_strobe (1 cycle) | o_found .. o_entry_count, o_last
//
// Insert, clear and unknown codes need no table scan; update and lookup scan
// the table with one table read per cycle through a single comparator
// (n = entries), and skip the scan on an empty table.
// Dump emits n results, one full table scan each; on an empty table it emits one result with no scan.
// Reset is synchronous and empties the table.
// busy is high from the cycle after start until the last result is issued;
// results cannot be stalled.
module key_ref_table_sorted_dump #(
    parameter int DEPTH     = 64,
    parameter int KEY_BYTES = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  i_operation,
    input  logic [krtsd_pkg::KEY_W-1:0] i_key,
    input  logic [krtsd_pkg::REF_W-1:0] i_ref_value,
    output logic                        o_strobe,
    output logic                        o_found,
    output logic [krtsd_pkg::REF_W-1:0] o_old_ref,
    output logic                        o_table_full,
    output logic                        o_entry_valid,
    output logic [krtsd_pkg::KEY_W-1:0] o_entry_key,
    output logic [krtsd_pkg::REF_W-1:0] o_entry_ref,
    output logic [krtsd_pkg::CNT_W-1:0] o_entry_count,
    output logic                        o_last
);

    krtsd_pkg::t_cmd    w_cmd;
    krtsd_pkg::t_status w_status;

    krtsd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    krtsd_dp #(
        .DEPTH     (DEPTH),
        .KEY_BYTES (KEY_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_operation   (i_operation),
        .i_key         (i_key),
        .i_ref_value   (i_ref_value),
        .o_strobe      (o_strobe),
        .o_found       (o_found),
        .o_old_ref     (o_old_ref),
        .o_table_full  (o_table_full),
        .o_entry_valid (o_entry_valid),
        .o_entry_key   (o_entry_key),
        .o_entry_ref   (o_entry_ref),
        .o_entry_count (o_entry_count),
        .o_last        (o_last)
    );

endmodule

/* test/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TBL_DEPTH   = 64;
    localparam int          N_ITEMS     = 230;
    localparam int          STALL_LIMIT = 5000;
    localparam logic [2:0]  OP_RSVD_LO  = 3'd5;
    localparam logic [2:0]  OP_RSVD_HI  = 3'd7;
    localparam logic [krtsd_pkg::REF_W-1:0] REF_MAX = {krtsd_pkg::REF_W{1'b1}};
    localparam logic [krtsd_pkg::KEY_W-1:0] KEY_MAX = {krtsd_pkg::KEY_W{1'b1}};

    typedef struct {
        logic [2:0]                  op;
        logic [krtsd_pkg::KEY_W-1:0] key;
        logic [krtsd_pkg::REF_W-1:0] refv;
        int                          idle_pct;
        bit                          hold;     // wait for every outstanding result first
    } t_table_cmd;

    typedef struct {
        logic                        found;
        logic [krtsd_pkg::REF_W-1:0] old_ref;
        logic                        table_full;
        logic                        entry_valid;
        logic [krtsd_pkg::KEY_W-1:0] entry_key;
        logic [krtsd_pkg::REF_W-1:0] entry_ref;
        logic [krtsd_pkg::CNT_W-1:0] entry_count;
        logic                        last;
    } t_table_result;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [2:0]                  i_operation;
    logic [krtsd_pkg::KEY_W-1:0] i_key;
    logic [krtsd_pkg::REF_W-1:0] i_ref_value;
    logic                        o_strobe;
    logic                        o_found;
    logic [krtsd_pkg::REF_W-1:0] o_old_ref;
    logic                        o_table_full;
    logic                        o_entry_valid;
    logic [krtsd_pkg::KEY_W-1:0] o_entry_key;
    logic [krtsd_pkg::REF_W-1:0] o_entry_ref;
    logic [krtsd_pkg::CNT_W-1:0] o_entry_count;
    logic                        o_last;

    t_table_cmd    pending_cmds[$];
    t_table_result expected_results[$];
    t_table_cmd    cur_cmd;
    int            n_queued;
    int            n_errors;
    int            stall_cycles;

    // shadow copy of the table
    logic [krtsd_pkg::KEY_W-1:0] shadow_keys[TBL_DEPTH];
    logic [krtsd_pkg::REF_W-1:0] shadow_refs[TBL_DEPTH];
    int                          shadow_count;

    logic [krtsd_pkg::KEY_W-1:0] key_pool[6];

    key_ref_table_sorted_dump DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_key         (i_key),
        .i_ref_value   (i_ref_value),
        .o_strobe      (o_strobe),
        .o_found       (o_found),
        .o_old_ref     (o_old_ref),
        .o_table_full  (o_table_full),
        .o_entry_valid (o_entry_valid),
        .o_entry_key   (o_entry_key),
        .o_entry_ref   (o_entry_ref),
        .o_entry_count (o_entry_count),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_table_result blank_result();
        t_table_result r;
        r.found       = 1'b0;
        r.old_ref     = '0;
        r.table_full  = 1'b0;
        r.entry_valid = 1'b0;
        r.entry_key   = '0;
        r.entry_ref   = '0;
        r.entry_count = krtsd_pkg::CNT_W'(shadow_count);
        r.last        = 1'b1;
        return r;
    endfunction

    // apply one command to the shadow table and queue the results it yields
    task automatic predict_table_op(input t_table_cmd c);
        t_table_result r;
        int            order[TBL_DEPTH];
        int            cur;
        int            j;
        bit            hit;
        hit = 1'b0;
        case (c.op)
            krtsd_pkg::OP_INSERT: begin
                if (shadow_count >= TBL_DEPTH) begin
                    r = blank_result();
                    r.table_full = 1'b1;
                end else begin
                    shadow_keys[shadow_count] = c.key;
                    shadow_refs[shadow_count] = c.refv;
                    shadow_count++;
                    r = blank_result();
                end
                expected_results.push_back(r);
            end
            krtsd_pkg::OP_UPDATE: begin
                r = blank_result();
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_keys[i] == c.key) begin
                        if (!hit) r.old_ref = shadow_refs[i];
                        hit = 1'b1;
                        shadow_refs[i] = c.refv;
                    end
                end
                r.found = hit;
                expected_results.push_back(r);
            end
            krtsd_pkg::OP_LOOKUP: begin
                r = blank_result();
                for (int i = 0; i < shadow_count; i++)
                    if (shadow_keys[i] == c.key) hit = 1'b1;
                r.found = hit;
                expected_results.push_back(r);
            end
            krtsd_pkg::OP_DUMP: begin
                if (shadow_count == 0) begin
                    expected_results.push_back(blank_result());
                end else begin
                    // newest first, then stable sort by key
                    for (int i = 0; i < shadow_count; i++) order[i] = shadow_count - 1 - i;
                    for (int i = 1; i < shadow_count; i++) begin
                        cur = order[i];
                        j = i;
                        while (j > 0 && shadow_keys[order[j-1]] > shadow_keys[cur]) begin
                            order[j] = order[j-1];
                            j--;
                        end
                        order[j] = cur;
                    end
                    for (int i = 0; i < shadow_count; i++) begin
                        r = blank_result();
                        r.entry_valid = 1'b1;
                        r.entry_key   = shadow_keys[order[i]];
                        r.entry_ref   = shadow_refs[order[i]];
                        r.last        = (i == shadow_count - 1);
                        expected_results.push_back(r);
                    end
                end
            end
            krtsd_pkg::OP_CLEAR: begin
                shadow_count = 0;
                expected_results.push_back(blank_result());
            end
            default: expected_results.push_back(blank_result());
        endcase
    endtask

    task automatic add_cmd(input logic [2:0] op, input logic [krtsd_pkg::KEY_W-1:0] key,
                           input logic [krtsd_pkg::REF_W-1:0] refv, input bit hold);
        t_table_cmd c;
        c.op       = op;
        c.key      = key;
        c.refv     = refv;
        c.hold     = hold;
        c.idle_pct = (n_queued < N_ITEMS / 3) ? 35 :
                     (n_queued < 2 * N_ITEMS / 3) ? 67 : 0;
        pending_cmds.push_back(c);
        n_queued++;
    endtask

    function automatic logic [krtsd_pkg::KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 60) return key_pool[$urandom_range(5)];
        if (r < 65) return '0;
        if (r < 70) return KEY_MAX;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [krtsd_pkg::REF_W-1:0] pick_ref();
        if ($urandom_range(19) == 0) return REF_MAX;
        return krtsd_pkg::REF_W'($urandom);
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            n_errors++;
        end
    endtask

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_operation <= '0;
            i_key       <= '0;
            i_ref_value <= '0;
        end else begin
            if (start && !busy) predict_table_op(cur_cmd);
            if (!start || !busy) begin
                if (pending_cmds.size() > 0 &&
                    (!pending_cmds[0].hold || expected_results.size() == 0) &&
                    $urandom_range(99) >= pending_cmds[0].idle_pct) begin
                    cur_cmd = pending_cmds.pop_front();
                    start       <= 1'b1;
                    i_operation <= cur_cmd.op;
                    i_key       <= cur_cmd.key;
                    i_ref_value <= cur_cmd.refv;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_table_result e;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, key %0h", $time, o_entry_key);
                n_errors++;
            end else begin
                e = expected_results.pop_front();
                check_field("found",       64'(e.found),       64'(o_found));
                check_field("old_ref",     64'(e.old_ref),     64'(o_old_ref));
                check_field("table_full",  64'(e.table_full),  64'(o_table_full));
                check_field("entry_valid", 64'(e.entry_valid), 64'(o_entry_valid));
                check_field("entry_key",   e.entry_key,        o_entry_key);
                check_field("entry_ref",   64'(e.entry_ref),   64'(o_entry_ref));
                check_field("entry_count", 64'(e.entry_count), 64'(o_entry_count));
                check_field("last",        64'(e.last),        64'(o_last));
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int k;
        int m;
        int r;
        int ep;
        n_queued     = 0;
        n_errors     = 0;
        shadow_count = 0;
        start        = 1'b0;
        i_operation  = '0;
        i_key        = '0;
        i_ref_value  = '0;
        i_rst_n      = 1'b0;
        key_pool[0] = 64'h6170706c65000000;
        key_pool[1] = 64'h6170706c65000001;
        key_pool[2] = 64'h0000000000000001;
        key_pool[3] = 64'h8000000000000000;
        key_pool[4] = {$urandom, $urandom};
        key_pool[5] = {$urandom, $urandom};

        // directed: empty table, extremes, duplicates, reserved codes
        add_cmd(krtsd_pkg::OP_DUMP,   '0, '0, 1'b0);
        add_cmd(krtsd_pkg::OP_LOOKUP, KEY_MAX, '0, 1'b0);
        add_cmd(krtsd_pkg::OP_UPDATE, '0, REF_MAX, 1'b0);
        add_cmd(krtsd_pkg::OP_INSERT, KEY_MAX, REF_MAX, 1'b0);
        add_cmd(krtsd_pkg::OP_INSERT, '0, '0, 1'b0);
        add_cmd(krtsd_pkg::OP_INSERT, key_pool[0], 31'h1, 1'b0);
        add_cmd(krtsd_pkg::OP_INSERT, key_pool[0], 31'h2, 1'b0);
        add_cmd(krtsd_pkg::OP_INSERT, key_pool[3], 31'h55555555, 1'b0);
        add_cmd(krtsd_pkg::OP_DUMP,   '0, '0, 1'b1);
        add_cmd(krtsd_pkg::OP_UPDATE, key_pool[0], 31'h2aaaaaaa, 1'b0);
        add_cmd(krtsd_pkg::OP_UPDATE, key_pool[1], 31'h3, 1'b0);
        add_cmd(krtsd_pkg::OP_LOOKUP, KEY_MAX, '0, 1'b0);
        add_cmd(krtsd_pkg::OP_LOOKUP, key_pool[2], '0, 1'b0);
        for (int op = OP_RSVD_LO; op <= OP_RSVD_HI; op++)
            add_cmd(3'(op), KEY_MAX, REF_MAX, 1'b0);
        add_cmd(krtsd_pkg::OP_DUMP,   '0, '0, 1'b0);
        add_cmd(krtsd_pkg::OP_CLEAR,  KEY_MAX, REF_MAX, 1'b0);
        add_cmd(krtsd_pkg::OP_DUMP,   '0, '0, 1'b0);
        add_cmd(krtsd_pkg::OP_LOOKUP, '0, '0, 1'b0);

        // random episodes: clear, fill, then a mix of operations
        ep = 0;
        while (n_queued < N_ITEMS) begin
            add_cmd(krtsd_pkg::OP_CLEAR, pick_key(), pick_ref(), $urandom_range(3) == 0);
            k = (ep == 2) ? TBL_DEPTH + 2 : $urandom_range(8);
            for (int i = 0; i < k; i++)
                add_cmd(krtsd_pkg::OP_INSERT, pick_key(), pick_ref(), 1'b0);
            m = $urandom_range(10, 3);
            for (int i = 0; i < m; i++) begin
                r = $urandom_range(99);
                if (r < 30)      add_cmd(krtsd_pkg::OP_UPDATE, pick_key(), pick_ref(), 1'b0);
                else if (r < 55) add_cmd(krtsd_pkg::OP_LOOKUP, pick_key(), pick_ref(), 1'b0);
                else if (r < 75) add_cmd(krtsd_pkg::OP_DUMP, pick_key(), pick_ref(), 1'b0);
                else if (r < 88) add_cmd(krtsd_pkg::OP_INSERT, pick_key(), pick_ref(), 1'b0);
                else if (r < 95) add_cmd(3'($urandom_range(OP_RSVD_HI, OP_RSVD_LO)),
                                         pick_key(), pick_ref(), 1'b0);
                else             add_cmd(krtsd_pkg::OP_CLEAR, pick_key(), pick_ref(), 1'b0);
            end
            ep++;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
sv/krtsd_pkg.sv
sv/krtsd_ctrl.sv
sv/krtsd_dp.sv
sv/key_ref_table_sorted_dump.sv
test/tb.sv
